[rtl/rrps_pkg.sv]
// ---------------------------------------------------------------------------
// rrps_pkg: shared types and constants of the probe retry scheduler
// Command, event and state codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
package rrps_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 64;

    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
    localparam logic [31:0] INIT_TIMEOUT_RST = 32'd500;
    localparam logic [31:0] INTERVAL_RST = 32'd10;
    localparam logic [15:0] BACKOFF_RST = 16'd384;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_REPLY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_IDLE    = 3'd0,
        EV_PROBE   = 3'd1,
        EV_TIMEOUT = 3'd2,
        EV_REPLIED = 3'd3,
        EV_UNKNOWN = 3'd4,
        EV_DEAD    = 3'd5,
        EV_FULL    = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        CFG_RETRY    = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_INTERVAL = 2'd2,
        CFG_BACKOFF  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_POLL_RD,
        ST_POLL_EVAL,
        ST_POLL_MUL,
        ST_POLL_WR,
        ST_SRCH_RD,
        ST_SRCH_EVAL,
        ST_ADV_RD,
        ST_ADV_EVAL,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic   load_in;     // capture input transfer
        logic   do_add;      // append entry, set result
        logic   poll_read;   // read cursor entry
        logic   poll_idle;   // set idle result
        logic   poll_retire; // retire cursor entry
        logic   poll_mul;    // register backoff product
        logic   poll_write;  // write probe bookkeeping
        logic   srch_start;  // init reverse search
        logic   srch_read;   // read search entry
        logic   srch_step;   // move search pointer back
        logic   srch_hit;    // record match
        logic   srch_miss;   // record no match
        logic   adv_start;   // init cursor walk
        logic   adv_read;    // read walk entry
        logic   adv_step;    // move walk pointer forward
        logic   adv_done;    // commit cursor
        logic   out_load;    // load output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic poll_ok;     // cursor entry due
        logic poll_expire; // retries used up
        logic srch_valid;  // search may start
        logic srch_match;  // current entry matches
        logic srch_last;   // last search step
        logic srch_live;   // matched entry live
        logic adv_need;    // walk is needed
        logic adv_found;   // walk entry live or walk ended
        logic retire_cur;  // retired entry is the cursor
    } dp_stat_t;

endpackage

[rtl/rrps_ctrl.sv]
// ---------------------------------------------------------------------------
// rrps_ctrl: scheduler controller
// Sequences add, poll, reply search and cursor walk over the datapath.
// ---------------------------------------------------------------------------
module rrps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    output logic              in_ready,
    input  logic              out_busy,
    output rrps_pkg::dp_cmd_t cmd,
    input  rrps_pkg::dp_stat_t stat
);
    import rrps_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_ADD:   state_next = ST_OUT;
                    CMD_POLL:  state_next = ST_POLL_RD;
                    CMD_REPLY: state_next = stat.srch_valid ? ST_SRCH_RD : ST_OUT;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_POLL_RD:   state_next = ST_POLL_EVAL;
            ST_POLL_EVAL: begin
                if (!stat.poll_ok) state_next = ST_OUT;
                else if (stat.poll_expire) state_next = ST_ADV_RD;
                else state_next = ST_POLL_MUL;
            end
            ST_POLL_MUL:  state_next = ST_POLL_WR;
            ST_POLL_WR:   state_next = ST_ADV_RD;
            ST_SRCH_RD:   state_next = ST_SRCH_EVAL;
            ST_SRCH_EVAL: begin
                if (stat.srch_match) begin
                    state_next = (stat.srch_live && stat.retire_cur) ? ST_ADV_RD : ST_OUT;
                end else if (stat.srch_last) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_ADV_RD: state_next = stat.adv_need ? ST_ADV_EVAL : ST_OUT;
            ST_ADV_EVAL: state_next = stat.adv_found ? ST_OUT : ST_ADV_RD;
            ST_OUT: begin
                if (!out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load_in = in_fire;
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_ADD:   cmd.do_add = 1'b1;
                    CMD_POLL:  cmd.poll_read = 1'b1;
                    CMD_REPLY: cmd.srch_start = 1'b1;
                    default:   cmd.poll_idle = 1'b1;
                endcase
            end
            ST_POLL_EVAL: begin
                if (!stat.poll_ok) cmd.poll_idle = 1'b1;
                else if (stat.poll_expire) begin
                    cmd.poll_retire = 1'b1;
                    cmd.adv_start = 1'b1;
                end
            end
            ST_POLL_MUL: cmd.poll_mul = 1'b1;
            ST_POLL_WR: begin
                cmd.poll_write = 1'b1;
                cmd.adv_start = 1'b1;
            end
            ST_SRCH_RD: cmd.srch_read = 1'b1;
            ST_SRCH_EVAL: begin
                if (stat.srch_match) begin
                    cmd.srch_hit = 1'b1;
                    cmd.adv_start = stat.srch_live && stat.retire_cur;
                end else if (stat.srch_last) begin
                    cmd.srch_miss = 1'b1;
                end else begin
                    cmd.srch_step = 1'b1;
                end
            end
            ST_ADV_RD: begin
                cmd.adv_read = stat.adv_need;
                cmd.adv_step = stat.adv_need;
            end
            ST_ADV_EVAL: cmd.adv_done = stat.adv_found;
            ST_OUT: cmd.out_load = !out_busy;
            default: ;
        endcase
    end

endmodule

[rtl/rrps_dp.sv]
// ---------------------------------------------------------------------------
// rrps_dp: scheduler datapath
// Entry table memory, live bits, counters, cursor, search and timing math.
// ---------------------------------------------------------------------------
module rrps_dp #(
    parameter int unsigned MAX_ENTRIES = rrps_pkg::MAX_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         in_command,
    input  logic [31:0]        in_host_addr,
    input  logic [31:0]        in_now_ms,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_data,
    input  rrps_pkg::dp_cmd_t  cmd,
    output rrps_pkg::dp_stat_t stat,
    output logic [2:0]         res_event,
    output logic [5:0]         res_index,
    output logic [31:0]        res_addr,
    output logic [6:0]         res_live,
    output logic [7:0]         res_sent
);
    import rrps_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = 32 + 32 + 8 + 32;
    localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

    // Configuration registers
    logic [7:0]  retry_reg;
    logic [31:0] init_to_reg, interval_reg;
    logic [15:0] backoff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_reg    <= RETRY_LIMIT_RST;
            init_to_reg  <= INIT_TIMEOUT_RST;
            interval_reg <= INTERVAL_RST;
            backoff_reg  <= BACKOFF_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_RETRY:    retry_reg    <= cfg_data[7:0];
                CFG_TIMEOUT:  init_to_reg  <= cfg_data;
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_BACKOFF:  backoff_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Captured input item
    logic [1:0]  cmd_reg;
    logic [31:0] addr_reg, now_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= in_command;
            addr_reg <= in_host_addr;
            now_reg  <= in_now_ms;
        end
    end

    // Entry memory: {address, timeout, sends, last_send}
    logic [MW-1:0] mem [MAX_ENTRIES];
    logic [MW-1:0] rd_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata;
    logic          mem_re;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_reg <= mem[mem_raddr];
    end

    logic [31:0] rd_addr, rd_to, rd_last;
    logic [7:0]  rd_sends;
    assign {rd_addr, rd_to, rd_sends, rd_last} = rd_reg;

    // Control state
    logic [MAX_ENTRIES-1:0] live_reg;
    logic [CW-1:0] count_reg, ltot_reg;
    logic [IW-1:0] cur_reg, ptr_reg, walk_reg;
    logic [CW-1:0] steps_reg;
    logic [31:0]   glast_reg;
    logic [47:0]   prod_reg;

    logic [IW-1:0] last_idx, walk_nx;
    assign last_idx = IW'(count_reg - CW'(1));
    assign walk_nx  = ({1'b0, walk_reg} + 1'b1 >= {1'b0, count_reg[IW-1:0]} &&
                       (CW'(walk_reg) + CW'(1) >= count_reg)) ? '0 : walk_reg + IW'(1);

    // Memory port selection
    always_comb begin
        mem_re    = cmd.poll_read | cmd.srch_read | cmd.adv_read;
        mem_raddr = cmd.poll_read ? cur_reg : (cmd.srch_read ? ptr_reg : walk_nx);
        mem_we    = cmd.do_add & (count_reg < MAXC);
        mem_waddr = IW'(count_reg);
        mem_wdata = {addr_reg, init_to_reg, 8'd0, 32'd0};
        if (cmd.poll_write) begin
            mem_we    = 1'b1;
            mem_waddr = cur_reg;
            mem_wdata = {rd_addr,
                         (rd_sends != 8'd0) ?
                             ((prod_reg[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod_reg[39:8])
                             : rd_to,
                         rd_sends + 8'd1, now_reg};
        end
    end

    // Status
    logic poll_ok;
    assign poll_ok = (ltot_reg != '0) && (CW'(cur_reg) < count_reg) && live_reg[cur_reg] &&
                     ((now_reg - glast_reg) >= interval_reg) &&
                     ((now_reg - rd_last) >= rd_to);
    always_comb begin
        stat.cmd         = cmd_t'(cmd_reg);
        stat.poll_ok     = poll_ok;
        stat.poll_expire = rd_sends >= retry_reg;
        stat.srch_valid  = CW'(cur_reg) < count_reg;
        stat.srch_match  = rd_addr == addr_reg;
        stat.srch_last   = steps_reg == CW'(1);
        stat.srch_live   = live_reg[ptr_reg];
        stat.retire_cur  = ptr_reg == cur_reg;
        stat.adv_need    = (ltot_reg != '0) && (steps_reg != '0);
        stat.adv_found   = live_reg[walk_reg] || (steps_reg == '0);
    end

    // State updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= '0;
            count_reg <= '0;
            ltot_reg  <= '0;
            cur_reg   <= '0;
            glast_reg <= '0;
            ptr_reg   <= '0;
            walk_reg  <= '0;
            steps_reg <= '0;
        end else begin
            // append entry
            if (cmd.do_add && count_reg < MAXC) begin
                live_reg[IW'(count_reg)] <= 1'b1;
                count_reg <= count_reg + CW'(1);
                ltot_reg  <= ltot_reg + CW'(1);
                if (ltot_reg == '0) cur_reg <= IW'(count_reg);
            end
            // retire cursor entry on expiry
            if (cmd.poll_retire) begin
                live_reg[cur_reg] <= 1'b0;
                if (ltot_reg != '0) ltot_reg <= ltot_reg - CW'(1);
            end
            if (cmd.poll_write) glast_reg <= now_reg;
            // retire on live reply match
            if (cmd.srch_hit && live_reg[ptr_reg]) begin
                live_reg[ptr_reg] <= 1'b0;
                if (ltot_reg != '0) ltot_reg <= ltot_reg - CW'(1);
            end
            // reverse search pointer
            if (cmd.srch_start) begin
                ptr_reg   <= cur_reg;
                steps_reg <= count_reg;
            end
            if (cmd.srch_step) begin
                ptr_reg   <= (ptr_reg == '0) ? last_idx : ptr_reg - IW'(1);
                steps_reg <= steps_reg - CW'(1);
            end
            // cursor walk
            if (cmd.adv_start) begin
                walk_reg  <= cur_reg;
                steps_reg <= count_reg;
            end
            if (cmd.adv_step) begin
                walk_reg  <= walk_nx;
                steps_reg <= steps_reg - CW'(1);
            end
            if (cmd.adv_done && steps_reg != '0) cur_reg <= walk_reg;
            if (cmd.adv_done && steps_reg == '0 && live_reg[walk_reg]) cur_reg <= walk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.poll_mul) prod_reg <= rd_to * backoff_reg;
    end

    // Result capture
    logic [2:0]  ev_reg;
    logic [5:0]  idx_reg;
    logic [31:0] raddr_reg;
    logic [7:0]  sent_reg;
    always_ff @(posedge aclk) begin
        if (cmd.do_add) begin
            ev_reg    <= (count_reg < MAXC) ? EV_IDLE : EV_FULL;
            idx_reg   <= (count_reg < MAXC) ? 6'(count_reg) : 6'd0;
            raddr_reg <= addr_reg;
            sent_reg  <= 8'd0;
        end
        if (cmd.poll_idle) begin
            ev_reg <= EV_IDLE; idx_reg <= '0; raddr_reg <= '0; sent_reg <= '0;
        end
        if (cmd.poll_retire) begin
            ev_reg <= EV_TIMEOUT; idx_reg <= 6'(cur_reg);
            raddr_reg <= rd_addr; sent_reg <= rd_sends;
        end
        if (cmd.poll_write) begin
            ev_reg <= EV_PROBE; idx_reg <= 6'(cur_reg);
            raddr_reg <= rd_addr; sent_reg <= rd_sends + 8'd1;
        end
        if (cmd.srch_hit) begin
            ev_reg <= live_reg[ptr_reg] ? EV_REPLIED : EV_DEAD;
            idx_reg <= 6'(ptr_reg); raddr_reg <= addr_reg; sent_reg <= rd_sends;
        end
        if (cmd.srch_miss || (cmd.srch_start && !(CW'(cur_reg) < count_reg))) begin
            ev_reg <= EV_UNKNOWN; idx_reg <= '0; raddr_reg <= addr_reg; sent_reg <= '0;
        end
    end

    assign res_event = ev_reg;
    assign res_index = idx_reg;
    assign res_addr  = raddr_reg;
    assign res_live  = 7'(ltot_reg);
    assign res_sent  = sent_reg;

endmodule

[rtl/round_robin_probe_retry_scheduler_core.sv]
// ---------------------------------------------------------------------------
// round_robin_probe_retry_scheduler_core: probe retry scheduler top level
// Round-robin retransmit scheduling with exponential backoff over a table.
// ---------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser {command}, tdata {now_ms, host_addr}
//  m_axis    out        tuser {event_res}, tdata {sent_count, live_remaining,
//                              entry_addr, entry_index}
//  cfg       in         cfg_index, cfg_data
//
// Add passes dispatch and output; poll passes read, evaluate and, for a probe,
// multiply and write, plus a walk step per entry passed; reply reads and
// evaluates per entry searched, plus the walk when the cursor entry is retired.
// Reset is synchronous; no clearing pass (live bits reset at once).
// A held result does not block accept of the next item; the item then waits
// in the output state until the result register is free.
module round_robin_probe_retry_scheduler_core #(
    parameter int unsigned MAX_ENTRIES = rrps_pkg::MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic [63:0] s_tdata,   // host_addr[31:0], now_ms[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic [55:0] m_tdata,   // entry_index[5:0], entry_addr[37:6],
                                   // live_remaining[44:38], sent_count[52:45]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rrps_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_fire;
    logic [2:0]  res_event;
    logic [5:0]  res_index;
    logic [31:0] res_addr;
    logic [6:0]  res_live;
    logic [7:0]  res_sent;
    logic        mv_reg;
    logic [55:0] md_reg;
    logic [2:0]  mu_reg;

    assign in_fire   = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    rrps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_ready (s_tready),
        .out_busy (mv_reg & ~m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rrps_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_command   (s_tuser),
        .in_host_addr (s_tdata[31:0]),
        .in_now_ms    (s_tdata[63:32]),
        .cfg_we       (cfg_valid),
        .cfg_idx      (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .res_event    (res_event),
        .res_index    (res_index),
        .res_addr     (res_addr),
        .res_live     (res_live),
        .res_sent     (res_sent)
    );

    // Output register: load on result, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            md_reg <= {3'd0, res_sent, res_live, res_addr, res_index};
            mu_reg <= res_event;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

endmodule

[test/round_robin_probe_retry_scheduler_core_test.sv]
// ---------------------------------------------------------------------------
// round_robin_probe_retry_scheduler_core_test: scheduler self-checking bench
// Drives add, poll, reply and unused commands with random gaps and output stalls,
// predicts every result from a behavioral copy of the probe table and
// compares each result transfer field by field in order.
// ---------------------------------------------------------------------------
module round_robin_probe_retry_scheduler_core_test;
    import rrps_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;

    // Probe table tracker: predicts each result and holds the pending ones
    class probe_scoreboard;
        logic [7:0]  retry_lim;
        logic [31:0] init_tmo;
        logic [31:0] gap_ms;
        logic [15:0] backoff;
        logic [31:0] addr_tab [TABLE_DEPTH];
        bit          live_tab [TABLE_DEPTH];
        logic [31:0] tmo_tab  [TABLE_DEPTH];
        logic [7:0]  sends_tab[TABLE_DEPTH];
        logic [31:0] last_tab [TABLE_DEPTH];
        int unsigned used;
        int unsigned live_cnt;
        int unsigned cursor;
        logic [31:0] last_probe;
        logic [63:0] pending_q[$];
        int          fails;

        function new();
            retry_lim = RETRY_LIMIT_RST;
            init_tmo  = INIT_TIMEOUT_RST;
            gap_ms    = INTERVAL_RST;
            backoff   = BACKOFF_RST;
            for (int i = 0; i < TABLE_DEPTH; i++) live_tab[i] = 0;
            used = 0;
            live_cnt = 0;
            cursor = 0;
            last_probe = '0;
            fails = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_RETRY:    retry_lim = val[7:0];
                CFG_TIMEOUT:  init_tmo  = val;
                CFG_INTERVAL: gap_ms    = val;
                default:      backoff   = val[15:0];
            endcase
        endfunction

        // Step the cursor forward to the next live entry
        function void seek_next_live();
            if (live_cnt == 0 || used == 0) return;
            for (int i = 0; i < used; i++) begin
                cursor = (cursor + 1 >= used) ? 0 : cursor + 1;
                if (live_tab[cursor]) return;
            end
        endfunction

        function void retire_entry(int unsigned idx);
            live_tab[idx] = 0;
            if (live_cnt > 0) live_cnt--;
            if (idx == cursor) seek_next_live();
        endfunction

        function void push_result(event_t ev, int unsigned idx, logic [31:0] addr,
                                  logic [7:0] sends);
            logic [63:0] r;
            r = '0;
            r[2:0]   = ev;
            r[8:3]   = idx[5:0];
            r[40:9]  = addr;
            r[47:41] = live_cnt[6:0];
            r[55:48] = sends;
            pending_q.push_back(r);
        endfunction

        // Note an accepted input transfer and queue its expected result
        function void note_item(cmd_t cmd, logic [31:0] addr, logic [31:0] now);
            int unsigned c;
            int unsigned p;
            logic [63:0] prod;
            case (cmd)
                CMD_ADD: begin
                    if (used >= TABLE_DEPTH) begin
                        push_result(EV_FULL, 0, addr, 8'd0);
                        return;
                    end
                    c = used;
                    addr_tab[c] = addr;
                    live_tab[c] = 1;
                    tmo_tab[c] = init_tmo;
                    sends_tab[c] = 8'd0;
                    last_tab[c] = '0;
                    used++;
                    if (live_cnt == 0) cursor = c;
                    live_cnt++;
                    push_result(EV_IDLE, c, addr, 8'd0);
                end
                CMD_POLL: begin
                    c = cursor;
                    if (live_cnt != 0 && c < used && live_tab[c] &&
                        (now - last_probe) >= gap_ms && (now - last_tab[c]) >= tmo_tab[c]) begin
                        if (sends_tab[c] >= retry_lim) begin
                            retire_entry(c);
                            push_result(EV_TIMEOUT, c, addr_tab[c], sends_tab[c]);
                            return;
                        end
                        if (sends_tab[c] != 0) begin
                            prod = (64'(tmo_tab[c]) * 64'(backoff)) >> 8;
                            tmo_tab[c] = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                        end
                        sends_tab[c] = sends_tab[c] + 8'd1;
                        last_tab[c] = now;
                        last_probe = now;
                        seek_next_live();
                        push_result(EV_PROBE, c, addr_tab[c], sends_tab[c]);
                    end else begin
                        push_result(EV_IDLE, 0, '0, 8'd0);
                    end
                end
                CMD_REPLY: begin
                    p = cursor;
                    if (p < used) begin
                        for (int i = 0; i < used; i++) begin
                            if (addr_tab[p] == addr) begin
                                if (live_tab[p]) begin
                                    retire_entry(p);
                                    push_result(EV_REPLIED, p, addr, sends_tab[p]);
                                end else begin
                                    push_result(EV_DEAD, p, addr, sends_tab[p]);
                                end
                                return;
                            end
                            p = (p == 0) ? used - 1 : p - 1;
                        end
                    end
                    push_result(EV_UNKNOWN, 0, addr, 8'd0);
                end
                default: push_result(EV_IDLE, 0, '0, 8'd0);
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            fails++;
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending_q.size() == 0) begin
                report("unexpected result", got, '0);
                return;
            end
            want = pending_q.pop_front();
            if (got[2:0] !== want[2:0])     report("event_res", got[2:0], want[2:0]);
            if (got[8:3] !== want[8:3])     report("entry_index", got[8:3], want[8:3]);
            if (got[40:9] !== want[40:9])   report("entry_addr", got[40:9], want[40:9]);
            if (got[47:41] !== want[47:41]) report("live_remaining", got[47:41], want[47:41]);
            if (got[55:48] !== want[55:48]) report("sent_count", got[55:48], want[55:48]);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    probe_scoreboard sb = new();
    bit              calm = 0;
    logic [31:0]     clock_ms = '0;
    logic [31:0]     known_addr[$];

    round_robin_probe_retry_scheduler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end

    // Stall the result channel in random bursts
    int unsigned stall_left = 0;
    always @(posedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (!calm) begin
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                rdy = 1'b0;
            end
        end
        m_tready <= rdy;
    end

    // Check each result transfer; sample before the edge, act after it
    always @(negedge aclk) begin
        logic        took;
        logic [63:0] data;
        took = m_tvalid && m_tready && aresetn;
        data = {8'd0, m_tdata[52:0], m_tuser};
        @(posedge aclk);
        if (took) sb.check_result(data);
    end

    // Send one input transfer, with an optional gap before it
    task send_item(cmd_t cmd, logic [31:0] addr, logic [31:0] now);
        int unsigned gap;
        logic rdy;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {now, addr};
        forever begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
            if (rdy) break;
        end
        sb.note_item(cmd, addr, now);
        if (cmd == CMD_ADD) known_addr.push_back(addr);
    endtask

    // Hold off input until every expected result has come, then let the
    // cursor walk settle
    task drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, logic [31:0] val);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
            if (rdy) break;
        end
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task set_regs(logic [7:0] retry, logic [31:0] tmo, logic [31:0] gap, logic [15:0] bk);
        write_reg(CFG_RETRY, {24'b0, retry});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_INTERVAL, gap);
        write_reg(CFG_BACKOFF, {16'b0, bk});
    endtask

    // Mostly polls with advancing time, some replies and a few adds
    task random_item(int unsigned step_max);
        int unsigned pick;
        logic [31:0] addr;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, step_max);
        if (pick < 5) begin
            addr = (known_addr.size() > 0 && $urandom_range(0, 4) == 0) ?
                   known_addr[$urandom_range(0, known_addr.size() - 1)] : $urandom();
            send_item(CMD_ADD, addr, $urandom());
        end else if (pick < 70) begin
            send_item(CMD_POLL, $urandom(), clock_ms);
        end else if (pick < 96) begin
            addr = (known_addr.size() > 0 && $urandom_range(0, 3) != 0) ?
                   known_addr[$urandom_range(0, known_addr.size() - 1)] : $urandom();
            send_item(CMD_REPLY, addr, $urandom());
        end else begin
            send_item(CMD_NONE, $urandom(), $urandom());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, unused code, address extremes, replies
        send_item(CMD_REPLY, 32'h0A00_0001, '0);
        send_item(CMD_POLL, '0, 32'd1000);
        send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'h0000_0000, '0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'h0A00_0002, '0);
        send_item(CMD_POLL, '0, 32'd0);
        send_item(CMD_POLL, '0, 32'd500);
        send_item(CMD_POLL, '0, 32'd505);
        send_item(CMD_POLL, '0, 32'd520);
        send_item(CMD_POLL, '0, 32'd540);
        send_item(CMD_POLL, '0, 32'd1100);
        send_item(CMD_POLL, '0, 32'hFFFF_FFFF);
        send_item(CMD_REPLY, 32'hFFFF_FFFF, '0);
        send_item(CMD_REPLY, 32'hFFFF_FFFF, '0);
        send_item(CMD_REPLY, 32'h1234_5678, '0);
        for (int i = 0; i < 6; i++) send_item(CMD_POLL, '0, 32'd3000 + 32'(i) * 800);
        drain();

        // Retire at once, zero interval and backoff
        set_regs(8'd0, 32'd0, 32'd0, 16'd0);
        send_item(CMD_ADD, 32'h0A00_0003, '0);
        send_item(CMD_POLL, '0, 32'd5);
        send_item(CMD_REPLY, 32'h0A00_0003, '0);
        drain();

        // Random phases over several settings, extremes among them
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_regs(8'd3, 32'd40, 32'd5, 16'd384);
                1: set_regs(8'd255, 32'd0, 32'd0, 16'hFFFF);
                2: set_regs(8'd2, 32'h1000_0000, 32'd0, 16'hFFFF);
                3: set_regs(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd256);
                4: set_regs(8'd1, 32'd20, 32'd0, 16'd128);
                default: set_regs(8'($urandom_range(0, 6)), 32'($urandom_range(0, 120)),
                                  32'($urandom_range(0, 15)), 16'($urandom_range(0, 700)));
            endcase
            if (ph == 6) calm = 1;
            for (int n = 0; n < 240; n++) random_item(ph == 3 ? 200 : 40);
            drain();
        end

        if (sb.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
